[sv/drcg_pkg.sv]
// ----------------------------------------------------------------------------
// drcg_pkg
// Shared constants, command and status types, and the cosine table math for
// the damped cosine rumble generator.
// ----------------------------------------------------------------------------
package drcg_pkg;

    // Field and internal widths fixed by the number formats.
    localparam int unsigned PH_W      = 16;  // Q0.16 phase in turns
    localparam int unsigned OUT_W     = 24;  // signed Q11.12 axis value
    localparam int unsigned COS_W     = 17;  // Q1.16 cosine magnitude, up to 1.0
    localparam int unsigned MAG_W     = 18;  // Q2.16, cosine plus one reaches 2.0
    localparam int unsigned CFG_W     = 16;  // widest configuration register
    localparam int unsigned IDX_W     = 3;   // configuration register index
    localparam int unsigned DIV_HI_W  = 16;  // divider partial remainder
    localparam int unsigned DIV_LO_W  = 24;  // dividend bits shifted in, MSB first
    localparam int unsigned DIV_CNT_W = 5;   // divider step counter

    localparam logic [MAG_W-1:0] ONE_Q16 = 18'h10000;

    // Divider step counts for the two divisions of a tick.
    localparam logic [DIV_CNT_W-1:0] PHASE_STEPS = 5'd24;
    localparam logic [DIV_CNT_W-1:0] AXIS_STEPS  = 5'd18;

    // Command codes.
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_STOP  = 2'd2;

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] REG_FREQUENCY    = 3'd0;
    localparam logic [IDX_W-1:0] REG_ANGLE_OFFSET = 3'd1;
    localparam logic [IDX_W-1:0] REG_AMPLITUDE    = 3'd2;
    localparam logic [IDX_W-1:0] REG_MAX_FRAME    = 3'd3;
    localparam logic [IDX_W-1:0] REG_WAVE_MODE    = 3'd4;

    // Reset values of the configuration and frame state.
    localparam logic [CFG_W-1:0] RST_FREQUENCY = 16'd256;
    localparam logic [CFG_W-1:0] RST_AMPLITUDE = 16'd4096;
    localparam logic [CFG_W-1:0] RST_MAX_FRAME = 16'd60;

    // Constants of the cosine series, used only while building the table.
    localparam longint unsigned Q30_ONE    = 64'd1 << 30;
    localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;
    localparam longint unsigned COS_DIVS [6] = '{64'd132, 64'd90, 64'd56, 64'd30, 64'd12, 64'd2};

    // Controller to datapath commands.
    typedef struct packed {
        logic accept;            // take the input command, update frame state
        logic phase_div_start;   // start the phase division
        logic phase_load;        // phase quotient into the axis phase register
        logic mul1;              // cosine magnitude times amplitude
        logic mul2;              // times remaining frames
        logic axis_div_start;    // start the axis scaling division
        logic axis_store;        // store the axis value, step to the next axis
        logic out_load;          // move results into the output register
    } drcg_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic tick_run;          // presented command is a tick inside a run
        logic div_busy;          // divider still iterating
        logic last_axis;         // working on the third axis
    } drcg_status_t;

    // Quarter-wave cosine of r / 2^bits turns, rounded to Q1.16. Evaluated at
    // elaboration only, to fill the cosine table.
    function automatic logic [COS_W-1:0] quarter_cos_q16(input longint unsigned r,
                                                         input int unsigned bits);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned p;
        longint unsigned t;
        x  = (r * TWO_PI_Q30) >> bits;
        x2 = (x * x) >> 30;
        p  = Q30_ONE;
        for (int i = 0; i < 6; i++)
        begin
            t = ((x2 * p) >> 30) / COS_DIVS[i];
            p = (t > Q30_ONE) ? 64'd0 : (Q30_ONE - t);
        end
        return COS_W'((p + 64'd8192) >> 14);
    endfunction

endpackage

[sv/drcg_cos_rom.sv]
// ----------------------------------------------------------------------------
// drcg_cos_rom
// Quarter-wave cosine table in Q1.16 with a registered read port.
// ----------------------------------------------------------------------------
module drcg_cos_rom #(
    parameter int TABLE_BITS = 10
) (
    input  logic                           clk,
    input  logic [TABLE_BITS-2:0]          addr,
    output logic [drcg_pkg::COS_W-1:0]     data
);

    localparam int QUARTER = 2 ** (TABLE_BITS - 2);

    typedef logic [drcg_pkg::COS_W-1:0] rom_t [0:QUARTER];

    function automatic rom_t build_rom();
        rom_t rom;
        for (int i = 0; i <= QUARTER; i++)
        begin
            rom[i] = drcg_pkg::quarter_cos_q16(64'(i), TABLE_BITS);
        end
        return rom;
    endfunction

    localparam rom_t COS_ROM = build_rom();

    logic [drcg_pkg::COS_W-1:0] data_reg;

    always_ff @(posedge clk)
    begin
        data_reg <= COS_ROM[addr];
    end

    assign data = data_reg;

endmodule

[sv/drcg_div.sv]
// ----------------------------------------------------------------------------
// drcg_div
// Restoring divider, one quotient bit per cycle. The partial remainder starts
// from the high dividend part, which must be below the divisor.
// ----------------------------------------------------------------------------
module drcg_div (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [drcg_pkg::DIV_HI_W-1:0]      hi,
    input  logic [drcg_pkg::DIV_LO_W-1:0]      lo,
    input  logic [drcg_pkg::DIV_CNT_W-1:0]     steps,
    input  logic [drcg_pkg::DIV_HI_W-1:0]      divisor,
    output logic                               busy,
    output logic [drcg_pkg::DIV_LO_W-1:0]      quot
);

    logic                              busy_reg;
    logic [drcg_pkg::DIV_CNT_W-1:0]    cnt_reg;
    logic [drcg_pkg::DIV_HI_W-1:0]     rem_reg;
    logic [drcg_pkg::DIV_HI_W-1:0]     divisor_reg;
    logic [drcg_pkg::DIV_LO_W-1:0]     shift_reg;
    logic [drcg_pkg::DIV_LO_W-1:0]     quot_reg;

    logic [drcg_pkg::DIV_HI_W:0]       trial;
    logic [drcg_pkg::DIV_HI_W:0]       diff;
    logic                              fits;

    assign trial = {rem_reg, shift_reg[drcg_pkg::DIV_LO_W-1]};
    assign diff  = trial - {1'b0, divisor_reg};
    assign fits  = trial >= {1'b0, divisor_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= steps;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == 1)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg     <= hi;
            shift_reg   <= lo;
            divisor_reg <= divisor;
            quot_reg    <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg   <= fits ? diff[drcg_pkg::DIV_HI_W-1:0] : trial[drcg_pkg::DIV_HI_W-1:0];
            shift_reg <= {shift_reg[drcg_pkg::DIV_LO_W-2:0], 1'b0};
            quot_reg  <= {quot_reg[drcg_pkg::DIV_LO_W-2:0], fits};
        end
    end

    assign busy = busy_reg;
    assign quot = quot_reg;

    // A partial remainder at or above the divisor would lose quotient bits.
    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (rem_reg < divisor_reg))
        else $error("divider remainder not below divisor");

endmodule

[sv/drcg_dp.sv]
// ----------------------------------------------------------------------------
// drcg_dp
// Datapath: configuration and frame registers, phase and scaling arithmetic,
// cosine table, shared divider, result and output registers.
// ----------------------------------------------------------------------------
module drcg_dp #(
    parameter int TABLE_BITS = 10
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  drcg_pkg::drcg_cmd_t                    cmd,
    output drcg_pkg::drcg_status_t                 status,
    input  logic [1:0]                             opcode,
    input  logic [15:0]                            new_frame_limit,
    input  logic                                   cfg_write,
    input  logic [drcg_pkg::IDX_W-1:0]             cfg_index,
    input  logic [drcg_pkg::CFG_W-1:0]             cfg_data,
    output logic signed [drcg_pkg::OUT_W-1:0]      out_x,
    output logic signed [drcg_pkg::OUT_W-1:0]      out_y,
    output logic signed [drcg_pkg::OUT_W-1:0]      out_z
);

    localparam int AXES   = 3;
    localparam int P1_W   = drcg_pkg::MAG_W + 16;   // magnitude times amplitude
    localparam int P2_W   = P1_W + 16;              // times remaining frames
    localparam int V_W    = 18;                     // scaled magnitude bound
    localparam logic [TABLE_BITS-2:0] QUARTER_ADDR = {1'b1, {(TABLE_BITS-2){1'b0}}};

    // Configuration and frame state.
    logic [15:0]   frequency_reg;
    logic [15:0]   angle_offset_reg;
    logic [15:0]   amplitude_reg;
    logic          wave_mode_reg;
    logic [15:0]   frame_count_reg;
    logic [15:0]   frame_limit_reg;

    // Per-command control.
    logic          tick_run_reg;
    logic [1:0]    axis_reg;

    // Arithmetic payload.
    logic [drcg_pkg::PH_W-1:0]     axp_reg;
    logic                          sign_reg;
    logic [P1_W-1:0]               p1_reg;
    logic [P2_W-1:0]               p2_reg;
    logic [drcg_pkg::OUT_W-1:0]    res_reg [AXES];
    logic [drcg_pkg::OUT_W-1:0]    out_x_reg;
    logic [drcg_pkg::OUT_W-1:0]    out_y_reg;
    logic [drcg_pkg::OUT_W-1:0]    out_z_reg;

    logic                          tick_run;
    logic [15:0]                   remain;
    logic [31:0]                   phase_prod;
    logic [P2_W:0]                 round_sum;
    logic [33:0]                   scaled;

    logic [TABLE_BITS-1:0]         q;
    logic [1:0]                    quad;
    logic [TABLE_BITS-3:0]         r;
    logic [TABLE_BITS-2:0]         rom_addr;
    logic [drcg_pkg::COS_W-1:0]    rom_data;
    logic                          quad_neg;
    logic [drcg_pkg::MAG_W-1:0]    cos_mag;
    logic                          cos_neg;

    logic                          div_start;
    logic [drcg_pkg::DIV_HI_W-1:0] div_hi;
    logic [drcg_pkg::DIV_LO_W-1:0] div_lo;
    logic [drcg_pkg::DIV_CNT_W-1:0] div_steps;
    logic                          div_busy;
    logic [drcg_pkg::DIV_LO_W-1:0] div_quot;
    logic [drcg_pkg::OUT_W-1:0]    v_ext;
    logic [drcg_pkg::OUT_W-1:0]    axis_val;

    assign tick_run = (opcode == drcg_pkg::OP_TICK) && (frame_count_reg < frame_limit_reg);
    assign remain   = frame_limit_reg - frame_count_reg;

    // Phase numerator frame_count * frequency; the extra factor 256 enters as
    // eight zero bits shifted in after the product.
    assign phase_prod = 32'(frame_count_reg) * 32'(frequency_reg);

    // Scaling with rounding half up: floor((P + limit * 2^15) / 2^16) / limit.
    assign round_sum = {1'b0, p2_reg} + (P2_W + 1)'({frame_limit_reg, 15'b0});
    assign scaled    = round_sum[49:16];

    // Cosine table address from the top bits of the axis phase.
    assign q        = axp_reg[drcg_pkg::PH_W-1 -: TABLE_BITS];
    assign quad     = q[TABLE_BITS-1 -: 2];
    assign r        = q[TABLE_BITS-3:0];
    assign rom_addr = quad[0] ? (QUARTER_ADDR - {1'b0, r}) : {1'b0, r};
    assign quad_neg = quad[0] ^ quad[1];

    always_comb
    begin
        if (wave_mode_reg)
        begin
            cos_neg = 1'b0;
            cos_mag = quad_neg ? (drcg_pkg::ONE_Q16 - {1'b0, rom_data})
                               : (drcg_pkg::ONE_Q16 + {1'b0, rom_data});
        end
        else
        begin
            cos_neg = quad_neg;
            cos_mag = {1'b0, rom_data};
        end
    end

    // Divider operand selection.
    assign div_start = cmd.phase_div_start | cmd.axis_div_start;

    always_comb
    begin
        if (cmd.phase_div_start)
        begin
            div_hi    = phase_prod[31:16];
            div_lo    = {phase_prod[15:0], 8'b0};
            div_steps = drcg_pkg::PHASE_STEPS;
        end
        else
        begin
            div_hi    = scaled[33:18];
            div_lo    = {scaled[17:0], 6'b0};
            div_steps = drcg_pkg::AXIS_STEPS;
        end
    end

    // The scaled magnitude stays below 2^17, so the signed result never
    // reaches the saturation limits.
    assign v_ext    = {{(drcg_pkg::OUT_W-V_W){1'b0}}, div_quot[V_W-1:0]};
    assign axis_val = sign_reg ? (~v_ext + 1'b1) : v_ext;

    drcg_cos_rom #(
        .TABLE_BITS (TABLE_BITS)
    ) u_cos_rom (
        .clk  (clk),
        .addr (rom_addr),
        .data (rom_data)
    );

    drcg_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .hi      (div_hi),
        .lo      (div_lo),
        .steps   (div_steps),
        .divisor (frame_limit_reg),
        .busy    (div_busy),
        .quot    (div_quot)
    );

    // Configuration, frame state and per-command control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frequency_reg    <= drcg_pkg::RST_FREQUENCY;
            angle_offset_reg <= '0;
            amplitude_reg    <= drcg_pkg::RST_AMPLITUDE;
            wave_mode_reg    <= 1'b0;
            frame_limit_reg  <= drcg_pkg::RST_MAX_FRAME;
            frame_count_reg  <= drcg_pkg::RST_MAX_FRAME;
            tick_run_reg     <= 1'b0;
            axis_reg         <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    drcg_pkg::REG_FREQUENCY:    frequency_reg    <= cfg_data;
                    drcg_pkg::REG_ANGLE_OFFSET: angle_offset_reg <= cfg_data;
                    drcg_pkg::REG_AMPLITUDE:    amplitude_reg    <= cfg_data;
                    drcg_pkg::REG_MAX_FRAME:    frame_limit_reg  <= cfg_data;
                    drcg_pkg::REG_WAVE_MODE:    wave_mode_reg    <= cfg_data[0];
                    default:                    ;
                endcase
            end

            if (cmd.accept)
            begin
                tick_run_reg <= tick_run;
                axis_reg     <= '0;
                case (opcode)
                    drcg_pkg::OP_START:
                    begin
                        frame_count_reg <= '0;
                        if (new_frame_limit != '0)
                        begin
                            frame_limit_reg <= new_frame_limit;
                        end
                    end
                    drcg_pkg::OP_STOP:
                    begin
                        frame_count_reg <= frame_limit_reg;
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (cmd.axis_store)
            begin
                axis_reg <= axis_reg + 1'b1;
            end

            if (cmd.out_load && tick_run_reg)
            begin
                frame_count_reg <= frame_count_reg + 1'b1;
            end
        end
    end

    // Arithmetic and result payload.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            for (int k = 0; k < AXES; k++)
            begin
                res_reg[k] <= '0;
            end
        end
        if (cmd.phase_load)
        begin
            axp_reg <= div_quot[drcg_pkg::PH_W-1:0];
        end
        if (cmd.mul1)
        begin
            p1_reg   <= P1_W'(cos_mag) * P1_W'(amplitude_reg);
            sign_reg <= cos_neg;
        end
        if (cmd.mul2)
        begin
            p2_reg <= P2_W'(p1_reg) * P2_W'(remain);
        end
        if (cmd.axis_store)
        begin
            res_reg[axis_reg] <= axis_val;
            axp_reg           <= axp_reg + angle_offset_reg;
        end
        if (cmd.out_load)
        begin
            out_x_reg <= res_reg[0];
            out_y_reg <= res_reg[1];
            out_z_reg <= res_reg[2];
        end
    end

    assign status.tick_run  = tick_run;
    assign status.div_busy  = div_busy;
    assign status.last_axis = (axis_reg == 2'(AXES - 1));

    assign out_x = out_x_reg;
    assign out_y = out_y_reg;
    assign out_z = out_z_reg;

endmodule

[sv/drcg_ctrl.sv]
// ----------------------------------------------------------------------------
// drcg_ctrl
// Controller: sequences the phase division and the three axis evaluations,
// and owns the input and output handshakes.
// ----------------------------------------------------------------------------
module drcg_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    output logic                      out_valid,
    input  logic                      out_ready,
    input  drcg_pkg::drcg_status_t    status,
    output drcg_pkg::drcg_cmd_t       cmd
);

    typedef enum logic [8:0] {
        S_IDLE      = 9'b0_0000_0001,
        S_PH_MUL    = 9'b0_0000_0010,
        S_PH_DIV    = 9'b0_0000_0100,
        S_AX_ROM    = 9'b0_0000_1000,
        S_AX_MUL1   = 9'b0_0001_0000,
        S_AX_MUL2   = 9'b0_0010_0000,
        S_AX_DSTART = 9'b0_0100_0000,
        S_AX_DIV    = 9'b0_1000_0000,
        S_WRITE     = 9'b1_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = status.tick_run ? S_PH_MUL : S_WRITE;
                end
            end
            S_PH_MUL:
            begin
                cmd.phase_div_start = 1'b1;
                state_next          = S_PH_DIV;
            end
            S_PH_DIV:
            begin
                if (!status.div_busy)
                begin
                    cmd.phase_load = 1'b1;
                    state_next     = S_AX_ROM;
                end
            end
            S_AX_ROM:
            begin
                state_next = S_AX_MUL1;
            end
            S_AX_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = S_AX_MUL2;
            end
            S_AX_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = S_AX_DSTART;
            end
            S_AX_DSTART:
            begin
                cmd.axis_div_start = 1'b1;
                state_next         = S_AX_DIV;
            end
            S_AX_DIV:
            begin
                if (!status.div_busy)
                begin
                    cmd.axis_store = 1'b1;
                    state_next     = status.last_axis ? S_WRITE : S_AX_ROM;
                end
            end
            S_WRITE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    // Commands that give zeros go straight to the output stage.
    a_zero_path: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && in_valid && !status.tick_run) |=> (state_reg == S_WRITE))
        else $error("zero result did not go straight to write");

    // The divider is never left running while the block waits for a command.
    a_idle_div_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !status.div_busy)
        else $error("divider busy while idle");

    // The divider only starts from the two states that issue a start.
    a_div_start_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(status.div_busy) |->
            ($past(state_reg) == S_PH_MUL || $past(state_reg) == S_AX_DSTART))
        else $error("divider started from an unexpected state");

endmodule

[sv/damped_cosine_rumble_generator.sv]
// ----------------------------------------------------------------------------
// damped_cosine_rumble_generator
// Three-axis damped cosine vibration source. Commands arrive as start, tick
// and stop transfers; every command returns exactly one result transfer with
// three signed Q11.12 axis values. A tick inside a run evaluates the phase
// frame * frequency / limit, looks up the cosine of that phase and of the two
// offset phases (the cosine plus one when the wave mode is set), and scales
// each by (1 - frame / limit) * amplitude; starts, stops, unused codes and
// ticks outside a run return zeros. The single shared divider produces one
// quotient bit per cycle while running. A tick inside a run first starts the
// divider for the phase, runs 24 steps and takes the quotient; then each of
// the three axes reads the table, does two multiplies, starts the divider,
// runs 18 steps and stores the value. The output register is then written
// and the next command accepted. Other commands go straight from acceptance
// to the output register write. The next command is accepted while a result
// still waits in the output register; the block stalls only when it must
// write a new result and the previous one has not yet been taken.
// Configuration writes take effect at once and must only be made while the
// block is idle.
// ----------------------------------------------------------------------------
module damped_cosine_rumble_generator #(
    parameter int COS_TABLE_BITS = 10
) (
    input  logic                                   clk,
    input  logic                                   rst_n,

    // Command channel.
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [1:0]                             opcode,
    input  logic [15:0]                            new_frame_limit,

    // Result channel.
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [drcg_pkg::OUT_W-1:0]      out_x,
    output logic signed [drcg_pkg::OUT_W-1:0]      out_y,
    output logic signed [drcg_pkg::OUT_W-1:0]      out_z,

    // Configuration write port: 0 frequency, 1 angle offset, 2 amplitude,
    // 3 max frame (loads the frame limit), 4 wave mode.
    input  logic                                   cfg_write,
    input  logic [drcg_pkg::IDX_W-1:0]             cfg_index,
    input  logic [drcg_pkg::CFG_W-1:0]             cfg_data
);

    drcg_pkg::drcg_cmd_t    cmd;
    drcg_pkg::drcg_status_t status;

    // The controller sequences each command through the datapath's shared
    // divider and multipliers and handles both transfer handshakes.
    drcg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // The datapath holds the configuration, the frame counter and limit, the
    // cosine table and the output register.
    drcg_dp #(
        .TABLE_BITS (COS_TABLE_BITS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .opcode          (opcode),
        .new_frame_limit (new_frame_limit),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .out_x           (out_x),
        .out_y           (out_y),
        .out_z           (out_z)
    );

endmodule
